// ===== hw/rtl/rhrb_pkg.sv =====
// Package for the RGB hue range builder.
// Types, codes and constants shared by the front, divider and back stages.
// No dependencies.
package rhrb_pkg;

    localparam int unsigned DIV_STAGES = 5;          // quotient bits, |q| <= 30

    localparam logic [7:0] HUE_TOP    = 8'd179;
    localparam logic [7:0] HUE_FULL   = 8'd180;
    localparam logic [7:0] GREEN_BASE = 8'd60;
    localparam logic [7:0] BLUE_BASE  = 8'd120;
    localparam logic [6:0] MARGIN_RESET = 7'd10;

    // which component is the maximum (grey when all are equal)
    typedef enum logic [1:0] {
        SECT_GREY,
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sect_t;

    // item moving through the divider chain
    typedef struct packed {
        sect_t       sect;
        logic        neg;     // numerator sign
        logic [12:0] rem;     // partial remainder, starts at 30*|n|
        logic [11:0] dsh;     // divisor shifted to the current quotient bit
        logic [4:0]  quo;     // quotient bits so far
    } div_t;

    // finished result item
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] first_low;
        logic [7:0] first_high;
        logic       second_valid;
        logic [7:0] second_low;
        logic [7:0] second_high;
    } result_t;

endpackage

// ===== hw/rtl/rhrb_front.sv =====
// Front of the hue pipeline: max/min search, sextant choice, numerator scaling.
// Two register stages. Depends on rhrb_pkg.
module rhrb_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      red,
    input  logic [7:0]      green,
    input  logic [7:0]      blue,
    output logic            out_valid,
    input  logic            out_ready,
    output rhrb_pkg::div_t  out_data
);
    import rhrb_pkg::*;

    // stage A
    logic       a_valid_reg;
    sect_t      a_sect_reg, a_sect_next;
    logic       a_neg_reg, a_neg_next;
    logic [7:0] a_abs_reg, a_abs_next;
    logic [7:0] a_d_reg, a_d_next;
    logic       a_ready;

    // stage B
    logic       b_valid_reg;
    div_t       b_data_reg, b_data_next;
    logic       b_ready;

    logic [7:0] mx, mn;
    logic [8:0] diff;

    always_comb begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        a_d_next = mx - mn;
        if (a_d_next == 8'd0) begin
            a_sect_next = SECT_GREY;
            diff        = 9'd0;
        end else if (mx == red) begin
            a_sect_next = SECT_RED;
            diff        = {1'b0, green} - {1'b0, blue};
        end else if (mx == green) begin
            a_sect_next = SECT_GREEN;
            diff        = {1'b0, blue} - {1'b0, red};
        end else begin
            a_sect_next = SECT_BLUE;
            diff        = {1'b0, red} - {1'b0, green};
        end
        a_neg_next = diff[8];
        a_abs_next = a_neg_next ? 8'(-diff) : diff[7:0];
    end

    // 30*|n| = 32*|n| - 2*|n|
    always_comb begin
        b_data_next.sect = a_sect_reg;
        b_data_next.neg  = a_neg_reg;
        b_data_next.rem  = {a_abs_reg, 5'd0} - {4'd0, a_abs_reg, 1'b0};
        b_data_next.dsh  = {a_d_reg, 4'd0};
        b_data_next.quo  = 5'd0;
    end

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) a_valid_reg <= in_valid;
            if (b_ready) b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_sect_reg <= a_sect_next;
            a_neg_reg  <= a_neg_next;
            a_abs_reg  <= a_abs_next;
            a_d_reg    <= a_d_next;
        end
        if (b_ready && a_valid_reg) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

// ===== hw/rtl/rhrb_div_stage.sv =====
// One restoring-division step: resolves one quotient bit per register stage.
// Depends on rhrb_pkg.
module rhrb_div_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  rhrb_pkg::div_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output rhrb_pkg::div_t  out_data
);
    import rhrb_pkg::*;

    logic valid_reg;
    div_t data_reg, data_next;
    logic ge;

    always_comb begin
        ge             = in_data.rem >= {1'b0, in_data.dsh};
        data_next      = in_data;
        data_next.rem  = ge ? (in_data.rem - {1'b0, in_data.dsh}) : in_data.rem;
        data_next.quo  = {in_data.quo[3:0], ge};
        data_next.dsh  = {1'b0, in_data.dsh[11:1]};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/rhrb_back.sv =====
// Back of the hue pipeline: floor correction, sextant offset, hue windows.
// Two register stages, the last one is the output register. Depends on rhrb_pkg.
module rhrb_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rhrb_pkg::div_t    in_data,
    input  logic [6:0]        hue_margin,
    output logic              out_valid,
    input  logic              out_ready,
    output rhrb_pkg::result_t out_data
);
    import rhrb_pkg::*;

    // stage C: hue
    logic       c_valid_reg;
    logic [7:0] c_hue_reg, c_hue_next;
    logic       c_ready;

    // stage D: windows
    logic       d_valid_reg;
    result_t    d_data_reg, d_data_next;
    logic       d_ready;

    logic       corr;
    logic [5:0] mag;
    logic [7:0] mag8;

    always_comb begin
        // negative quotients round toward minus infinity
        corr = in_data.neg && (in_data.rem != 13'd0);
        mag  = {1'b0, in_data.quo} + {5'd0, corr};
        mag8 = {2'd0, mag};
        case (in_data.sect)
            SECT_GREY:  c_hue_next = 8'd0;
            SECT_RED:   c_hue_next = (in_data.neg && mag != 6'd0) ? (HUE_FULL - mag8) : mag8;
            SECT_GREEN: c_hue_next = in_data.neg ? (GREEN_BASE - mag8) : (GREEN_BASE + mag8);
            SECT_BLUE:  c_hue_next = in_data.neg ? (BLUE_BASE - mag8) : (BLUE_BASE + mag8);
            default:    c_hue_next = 8'd0;
        endcase
    end

    logic [8:0] h9, m9, sum9, top9;
    logic       below, over;

    always_comb begin
        h9    = {1'b0, c_hue_reg};
        m9    = {2'd0, hue_margin};
        top9  = {1'b0, HUE_TOP};
        sum9  = h9 + m9;
        below = h9 < m9;
        over  = sum9 > top9;

        d_data_next.hue        = c_hue_reg;
        d_data_next.first_low  = below ? 8'd0 : 8'(h9 - m9);
        d_data_next.first_high = over ? HUE_TOP : sum9[7:0];
        if (below) begin
            d_data_next.second_valid = 1'b1;
            d_data_next.second_low   = 8'(top9 + h9 - m9);
            d_data_next.second_high  = HUE_TOP;
        end else if (over) begin
            d_data_next.second_valid = 1'b1;
            d_data_next.second_low   = 8'd0;
            d_data_next.second_high  = 8'(sum9 - top9);
        end else begin
            d_data_next.second_valid = 1'b0;
            d_data_next.second_low   = 8'd0;
            d_data_next.second_high  = 8'd0;
        end
    end

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (c_ready) c_valid_reg <= in_valid;
            if (d_ready) d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && in_valid) begin
            c_hue_reg <= c_hue_next;
        end
        if (d_ready && c_valid_reg) begin
            d_data_reg <= d_data_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

endmodule

// ===== hw/rtl/rgb_hue_range_builder_unit.sv =====
// RGB hue range builder, top level: 0..179 hue of an RGB item plus hue windows.
// Nine register stages; throughput one item per cycle while m_ready is high.
// Most of the depth is the 5-step divider chain (one quotient bit per stage).
// aresetn (sync, active low) empties the pipeline and sets hue_margin to 10.
// Depends on rhrb_pkg, rhrb_front, rhrb_div_stage, rhrb_back.
module rgb_hue_range_builder_unit (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration: hue_margin
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    // input items
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    // result items
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_hue,
    output logic [7:0] m_first_low,
    output logic [7:0] m_first_high,
    output logic       m_second_valid,
    output logic [7:0] m_second_low,
    output logic [7:0] m_second_high
);
    import rhrb_pkg::*;

    // Pipeline map:
    //   front  : 2 stages (max/min + sextant, then numerator 30*|n|)
    //   divider: DIV_STAGES stages, restoring division, MSB first
    //   back   : 2 stages (floor fix + sextant offset, then windows)
    // Each stage holds its own valid bit and accepts when empty or when
    // the next stage takes its item, so bubbles collapse under stall.

    logic [6:0] hue_margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_margin_reg <= MARGIN_RESET;
        end else if (cfg_we) begin
            hue_margin_reg <= cfg_wdata;
        end
    end

    // divider chain links: index 0 is the front output, DIV_STAGES the last
    logic  div_valid [DIV_STAGES+1];
    logic  div_ready [DIV_STAGES+1];
    div_t  div_data  [DIV_STAGES+1];

    result_t res;

    rhrb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .red       (s_red),
        .green     (s_green),
        .blue      (s_blue),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        rhrb_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    // user must change margin only while idle (block won't enforce); read live
    rhrb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (div_valid[DIV_STAGES]),
        .in_ready   (div_ready[DIV_STAGES]),
        .in_data    (div_data[DIV_STAGES]),
        .hue_margin (hue_margin_reg),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (res)
    );

    assign m_hue          = res.hue;
    assign m_first_low    = res.first_low;
    assign m_first_high   = res.first_high;
    assign m_second_valid = res.second_valid;
    assign m_second_low   = res.second_low;
    assign m_second_high  = res.second_high;

endmodule
